FILE: design/smf_pkg.sv
package smf_pkg;

  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd5;

  typedef struct packed {
    logic issue;
    logic j_lt_i;
    logic clear;
  } rank_ctl_t;

endpackage

FILE: design/smf_window_ram.sv
module smf_window_ram #(
  parameter int DEPTH = 15,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_off_a,
  input  logic [AW-1:0]    rd_off_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    wptr_next;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;

  // offset 0 is the newest entry
  function automatic logic [AW-1:0] off_to_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
    logic [AW:0] wrap;
    wrap = {1'b0, base} + (AW+1)'(DEPTH) - {1'b0, off};
    if (base >= off) begin
      return base - off;
    end else begin
      return wrap[AW-1:0];
    end
  endfunction

  assign wptr_next = (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign addr_a    = off_to_addr(wptr, rd_off_a);
  assign addr_b    = off_to_addr(wptr, rd_off_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
    end else if (wr_en) begin
      wptr <= wptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_next] <= wr_data;
    end
    rd_data_a <= mem[addr_a];
    rd_data_b <= mem[addr_b];
  end

endmodule

FILE: design/smf_rank_unit.sv
module smf_rank_unit #(
  parameter int SAMPLE_BITS = 32,
  parameter int CW          = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  smf_pkg::rank_ctl_t     ctl,
  input  logic [SAMPLE_BITS-1:0] cand,
  input  logic [SAMPLE_BITS-1:0] other,
  output logic [CW-1:0]          rank_sum
);

  logic          cmp_valid;
  logic          cmp_j_lt_i;
  logic          less;
  logic [CW-1:0] rank;

  // stable order: ties broken by store offset
  assign less = ($signed(other) < $signed(cand)) || ((other == cand) && cmp_j_lt_i);
  assign rank_sum = rank + CW'(cmp_valid && less);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid  <= 1'b0;
      cmp_j_lt_i <= 1'b0;
      rank       <= '0;
    end else begin
      cmp_valid  <= ctl.issue;
      cmp_j_lt_i <= ctl.j_lt_i;
      rank       <= ctl.clear ? '0 : rank_sum;
    end
  end

endmodule

FILE: design/sliding_median_filter_top.sv
// Centered sliding median over a curve of signed samples, one rank comparator
// shared by all positions. For each result that a request releases, each
// candidate sample is ranked against the whole truncated window of cnt samples
// (up to 15 at the default depth) one compare per cycle until the one of rank
// cnt/2 is found. s_tready is low from acceptance until every result of that
// request has been taken. The user must write window_size through cfg_* only
// while the block is idle; the block itself does not enforce it. An even size
// acts as the next odd one, zero as pass-through. A result for position i
// leaves once sample i+half has arrived, and the request with s_tlast set
// flushes all pending positions, m_tlast marking the final one.
module sliding_median_filter_top #(
  parameter int MAX_WINDOW  = 15,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smf_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // median
  output logic                                m_tlast
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int TW  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CAP = (MAX_WINDOW - 1) / 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_RANK,
    ST_OUT
  } state_t;

  state_t                         state;
  logic [smf_pkg::CFG_BITS-1:0]   window_size;
  logic [CW-1:0]                  seen;
  logic [CW-1:0]                  pend;
  logic [CW-1:0]                  half;
  logic                           lst;
  logic [AW-1:0]                  lo;
  logic [AW-1:0]                  hi;
  logic [AW-1:0]                  i_off;
  logic [AW-1:0]                  j_off;
  logic [CW-1:0]                  target;
  logic [SAMPLE_BITS-1:0]         median;

  logic                           accept;
  logic [smf_pkg::CFG_BITS-1:0]   ws_half;
  logic [CW-1:0]                  d;
  logic [CW-1:0]                  lo_c;
  logic [CW:0]                    span_top;
  logic [CW-1:0]                  last_idx;
  logic [CW-1:0]                  hi_c;
  logic [CW-1:0]                  cnt_c;
  logic                           emit;
  logic [SAMPLE_BITS-1:0]         rd_cand;
  logic [SAMPLE_BITS-1:0]         rd_other;
  logic [CW-1:0]                  rank_sum;
  smf_pkg::rank_ctl_t             rctl;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = TW'(median);

  assign ws_half  = window_size >> 1;
  assign d        = pend - 1'b1;
  assign lo_c     = (d > half) ? d - half : '0;
  assign span_top = {1'b0, d} + {1'b0, half};
  assign last_idx = seen - 1'b1;
  assign hi_c     = (span_top > {1'b0, last_idx}) ? last_idx : span_top[CW-1:0];
  assign cnt_c    = hi_c - lo_c + 1'b1;
  assign emit     = lst ? (pend != '0) : (pend > half);

  assign rctl.issue  = (state == ST_SCAN);
  assign rctl.j_lt_i = (j_off < i_off);
  assign rctl.clear  = (state == ST_CHECK) || (state == ST_RANK);

  smf_window_ram #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept),
    .wr_data   (s_tdata[SAMPLE_BITS-1:0]),
    .rd_off_a  (i_off),
    .rd_off_b  (j_off),
    .rd_data_a (rd_cand),
    .rd_data_b (rd_other)
  );

  smf_rank_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW)
  ) u_rank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rctl),
    .cand     (rd_cand),
    .other    (rd_other),
    .rank_sum (rank_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= smf_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seen     <= '0;
      pend     <= '0;
      half     <= '0;
      lst      <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (seen != CW'(MAX_WINDOW)) seen <= seen + 1'b1;
            if (pend != CW'(MAX_WINDOW)) pend <= pend + 1'b1;
            if (int'(ws_half) > CAP) begin
              half <= CW'(CAP);
            end else begin
              half <= CW'(ws_half);
            end
            lst   <= s_tlast;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (emit) begin
            lo      <= lo_c[AW-1:0];
            hi      <= hi_c[AW-1:0];
            i_off   <= lo_c[AW-1:0];
            j_off   <= lo_c[AW-1:0];
            target  <= cnt_c >> 1;
            m_tlast <= lst && (d == '0);
            state   <= ST_SCAN;
          end else begin
            if (lst) begin
              seen <= '0;
              pend <= '0;
            end
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (j_off == hi) begin
            state <= ST_RANK;
          end else begin
            j_off <= j_off + 1'b1;
          end
        end
        ST_RANK: begin
          if (rank_sum == target) begin
            median   <= rd_cand;
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end else begin
            i_off <= i_off + 1'b1;
            j_off <= lo;
            state <= ST_SCAN;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            pend     <= pend - 1'b1;
            state    <= ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input taken while a result is held");

  a_pend_le_seen: assert property (@(posedge clk) disable iff (rst)
    pend <= seen)
    else $error("pending count exceeds stored samples");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> pend == '0)
    else $error("positions left after final result");

  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_RANK |-> (rank_sum == target || i_off != hi))
    else $error("no window element holds the median rank");

endmodule

FILE: bench/sliding_median_filter_top_tb.sv
`timescale 1ns / 100ps

module sliding_median_filter_top_tb;

  localparam int DEPTH    = 15;
  localparam int HALF_CAP = (DEPTH - 1) / 2;
  localparam int SETTLE   = 30;
  localparam int CB       = smf_pkg::CFG_BITS;

  typedef logic signed [31:0] sample_t;

  typedef struct {
    sample_t median;
    bit      last;
  } median_result_t;

  class median_tracker;
    sample_t                  recent [DEPTH];  // newest first
    int unsigned              filled;
    int unsigned              waiting;
    logic [smf_pkg::CFG_BITS-1:0] win_size;
    median_result_t           due [$];
    int unsigned              errors;

    function new();
      filled   = 0;
      waiting  = 0;
      win_size = smf_pkg::CFG_RESET;
      errors   = 0;
      foreach (recent[i]) recent[i] = '0;
    endfunction

    function sample_t middle_of(int unsigned d, int unsigned half);
      sample_t     sorted [DEPTH];
      sample_t     v;
      int unsigned lo, hi, n, i, j;
      lo = (d > half) ? d - half : 0;
      hi = d + half;
      if (hi > filled - 1) hi = filled - 1;
      n = 0;
      for (i = lo; i <= hi; i++) begin
        v = recent[i];
        j = n;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
        n++;
      end
      return sorted[n/2];
    endfunction

    function void note_sample(sample_t s, bit lst);
      int unsigned    w, half, d;
      median_result_t r;
      w = (win_size == 0) ? 1 : win_size;
      if (w % 2 == 0) w++;
      half = w / 2;
      if (half > HALF_CAP) half = HALF_CAP;
      for (int i = DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = s;
      if (filled < DEPTH) filled++;
      if (waiting < DEPTH) waiting++;
      // flush everything on last, else release positions whose window is complete
      while (waiting > (lst ? 0 : half)) begin
        d = waiting - 1;
        r.median = middle_of(d, half);
        r.last   = lst && (d == 0);
        due.insert(due.size(), r);
        waiting--;
      end
      if (lst) begin
        filled  = 0;
        waiting = 0;
      end
    endfunction

    function void check_median(sample_t m, bit lst);
      median_result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: median %0d last %0b", m, lst);
        return;
      end
      want = due.pop_front();
      if (m !== want.median || lst !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: median exp %0d got %0d, last exp %0b got %0b",
                   want.median, m, want.last, lst);
      end
    endfunction
  endclass

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [smf_pkg::CFG_BITS-1:0] cfg_data  = '0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [31:0]                  s_tdata   = '0;  // sample
  logic                         s_tlast   = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [31:0]                  m_tdata;          // median
  logic                         m_tlast;

  median_tracker tracker = new();

  int unsigned send_idle = 9;
  int unsigned recv_idle = 60;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;

  sliding_median_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_median($signed(m_tdata), m_tlast);
  end

  task automatic send_sample(input sample_t v, input bit lst);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    tracker.note_sample(v, lst);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [smf_pkg::CFG_BITS-1:0] w);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.win_size = w;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return int'($urandom_range(8)) - 4;  // small values give ties
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sample_t     edge_vals [8];
    int unsigned sent, len, cut;
    int          i, ph;

    edge_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
                  32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0100};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default window after reset, extremes, flush on last
    for (i = 0; i < 8; i++) send_sample(edge_vals[i], i == 7);
    // curve of one sample, window cut on both sides
    send_sample(-5, 1'b1);

    set_window(CB'(0));
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(7, 1'b1);

    // maximum window, then shrink mid-curve to an even size
    set_window(CB'(15));
    for (i = 0; i < 9; i++) send_sample(pick_sample(), 1'b0);
    set_window(CB'(2));
    send_sample(-3, 1'b0);
    send_sample(3, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 9 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 9 : 0;
      sent = 0;
      while (sent < 30) begin
        len = $urandom_range(1, 16);
        cut = ($urandom_range(3) == 0) ? $urandom_range(1, len) : 0;
        if (ph == 2 && sent == 0) begin
          len = 16;
          cut = 0;
          hold_req = 1'b1;
        end
        for (i = 0; i < len; i++) begin
          if (cut != 0 && i == cut) set_window(CB'($urandom_range(15)));
          send_sample(pick_sample(), i == len - 1);
          sent++;
        end
        if ($urandom_range(1) == 1) set_window(CB'($urandom_range(15)));
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
design/smf_pkg.sv
design/smf_window_ram.sv
design/smf_rank_unit.sv
design/sliding_median_filter_top.sv
bench/sliding_median_filter_top_tb.sv
